@@ src/slex_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package slex_pkg;

  // Defaults for the top-level parameters.
  localparam int KEYWORD_MAX_LEN_DEF = 10;
  localparam int POSITION_BITS_DEF   = 16;

  localparam logic [3:0] TAB_WIDTH_RESET = 4'd4;
  localparam int QUEUE_DEPTH = 4;
  localparam int FRAC_LIMIT  = 10;
  localparam logic [34:0] VALUE_MAX = 35'h7FFF_FFFF;

  // Lexer modes.
  localparam logic [2:0] M_INITIAL = 3'd0;
  localparam logic [2:0] M_IDENT   = 3'd1;
  localparam logic [2:0] M_NUMERIC = 3'd2;
  localparam logic [2:0] M_FLOAT   = 3'd3;
  localparam logic [2:0] M_EQ      = 3'd4;
  localparam logic [2:0] M_LT      = 3'd5;
  localparam logic [2:0] M_GT      = 3'd6;

  // Token codes.
  localparam logic [5:0] C_KEYWORD0 = 6'd15;
  localparam logic [5:0] C_ASSIGN   = 6'd47;
  localparam logic [5:0] C_EQUAL    = 6'd48;
  localparam logic [5:0] C_LESS     = 6'd49;
  localparam logic [5:0] C_LESS_EQ  = 6'd50;
  localparam logic [5:0] C_GREATER  = 6'd51;
  localparam logic [5:0] C_GREATER_EQ = 6'd52;
  localparam logic [5:0] C_IDENT    = 6'd53;
  localparam logic [5:0] C_INT      = 6'd54;
  localparam logic [5:0] C_REAL     = 6'd55;
  localparam logic [5:0] C_FAIL     = 6'd56;
  localparam logic [5:0] C_EOF      = 6'd57;

  localparam int KW_COUNT = 32;

  // Keyword text, right-justified, first character in the highest byte in use.
  localparam logic [127:0] KW_TEXT [KW_COUNT] = '{
    128'("in"), 128'("out"), 128'("inout"), 128'("const"), 128'("uniform"),
    128'("void"), 128'("float"), 128'("vec2"), 128'("vec3"), 128'("vec4"),
    128'("return"), 128'("dot"), 128'("cross"), 128'("length"), 128'("sin"),
    128'("asin"), 128'("cos"), 128'("acos"), 128'("tan"), 128'("atan"),
    128'("accumulate"), 128'("normalize"), 128'("sqrt"), 128'("invsqrt"),
    128'("max"), 128'("min"), 128'("floor"), 128'("ceil"), 128'("sampler"),
    128'("sample1D"), 128'("sample2D"), 128'("sample3D")
  };

  localparam logic [7:0] KW_LEN [KW_COUNT] = '{
    8'd2, 8'd3, 8'd5, 8'd5, 8'd7, 8'd4, 8'd5, 8'd4, 8'd4, 8'd4,
    8'd6, 8'd3, 8'd5, 8'd6, 8'd3, 8'd4, 8'd3, 8'd4, 8'd3, 8'd4,
    8'd10, 8'd9, 8'd4, 8'd7, 8'd3, 8'd3, 8'd5, 8'd4, 8'd7, 8'd8,
    8'd8, 8'd8
  };

  typedef struct packed {
    logic [7:0] char_byte;
    logic       end_of_text;
  } item_t;

  typedef struct packed {
    logic [5:0]  token_code;
    logic [30:0] number_value;
    logic [3:0]  fraction_digits;
    logic [7:0]  name_length;
    logic [15:0] row_number;
    logic [15:0] column_number;
    logic        last_of_run;
  } result_t;

  // Up to two tokens written into the queue in one cycle.
  typedef struct packed {
    logic    valid0;
    logic    valid1;
    result_t tok0;
    result_t tok1;
  } qwrite_t;

  // Character i of keyword k, zero past its end.
  function automatic logic [7:0] kw_byte(input int k, input int i);
    logic [7:0] r;
    r = 8'h00;
    if (i < int'(KW_LEN[k])) r = KW_TEXT[k][(int'(KW_LEN[k]) - 1 - i) * 8 +: 8];
    return r;
  endfunction

  // Code of a single-character token, or the failure code.
  function automatic logic [5:0] single_code(input logic [7:0] b);
    logic [5:0] r;
    case (b)
      8'h3B: r = 6'd0;
      8'h3A: r = 6'd1;
      8'h2E: r = 6'd2;
      8'h3F: r = 6'd3;
      8'h2C: r = 6'd4;
      8'h28: r = 6'd5;
      8'h29: r = 6'd6;
      8'h7B: r = 6'd7;
      8'h7D: r = 6'd8;
      8'h5B: r = 6'd9;
      8'h5D: r = 6'd10;
      8'h2B: r = 6'd11;
      8'h2D: r = 6'd12;
      8'h2A: r = 6'd13;
      8'h2F: r = 6'd14;
      default: r = C_FAIL;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

@@ src/shader_source_lexer_core.sv @@
// A token is written into the token queue when the byte that closes it is taken.
// One byte per cycle unless stalled; a byte may give two tokens, written together.
// The input stalls only while the four-entry token queue has fewer than two free slots.
// Reset (rst, synchronous): lexer idle, position 0/0, queue empty, tab width 4.
`timescale 1ns / 1ps
`default_nettype none

module shader_source_lexer_core #(
  parameter int KEYWORD_MAX_LEN = slex_pkg::KEYWORD_MAX_LEN_DEF,
  parameter int POSITION_BITS   = slex_pkg::POSITION_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  output logic                   full,
  input  wire slex_pkg::item_t   item,
  output logic                   empty,
  input  wire logic              pop,
  output slex_pkg::result_t      result,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [3:0]        cfg_data
);

  logic              accept;
  logic [3:0]        tab_width;
  slex_pkg::qwrite_t qwr;

  assign accept    = push && !full;
  assign cfg_ready = 1'b1;

  // Tab width register.
  always_ff @(posedge clk) begin
    if (rst) begin
      tab_width <= slex_pkg::TAB_WIDTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      tab_width <= cfg_data;
    end
  end

  slex_front #(
    .KEYWORD_MAX_LEN(KEYWORD_MAX_LEN),
    .POSITION_BITS(POSITION_BITS)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .accept(accept),
    .item(item),
    .tab_width(tab_width),
    .qwr(qwr)
  );

  slex_queue u_queue (
    .clk(clk),
    .rst(rst),
    .qwr(qwr),
    .pop(pop),
    .full(full),
    .empty(empty),
    .head(result)
  );

endmodule

`default_nettype wire

@@ src/slex_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module slex_front #(
  parameter int KEYWORD_MAX_LEN = slex_pkg::KEYWORD_MAX_LEN_DEF,
  parameter int POSITION_BITS   = slex_pkg::POSITION_BITS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             accept,
  input  wire slex_pkg::item_t  item,
  input  wire logic [3:0]       tab_width,
  output slex_pkg::qwrite_t     qwr
);

  localparam int KIDX = (KEYWORD_MAX_LEN > 1) ? $clog2(KEYWORD_MAX_LEN) : 1;
  localparam int P = POSITION_BITS;
  localparam int KW_COUNT_W = 5;

  // Lexer state.
  logic [2:0]   mode, mode_next;
  logic [7:0]   kbuf [KEYWORD_MAX_LEN];
  logic [7:0]   plen, plen_next;
  logic [30:0]  acc, acc_next;
  logic [3:0]   frac, frac_next;
  logic         ovf, ovf_next;
  logic [P-1:0] row, row_next;
  logic [P-1:0] col, col_next;
  logic         kbuf_we;
  logic [KIDX-1:0] kbuf_wa;

  logic [7:0] b;
  logic       is_digit, is_alpha, is_ws;
  logic [3:0] dval;
  logic [34:0] acc10;
  logic [P:0]  col_sum;
  logic [P-1:0] row_adv, col_adv;
  logic [KW_COUNT_W-1:0] kw_hit_idx;
  logic        kw_hit;
  logic [5:0]  close_code;
  logic [30:0] close_val;
  logic [3:0]  close_frac;
  logic [7:0]  close_len;
  logic [P+15:0] row_ext_old, col_ext_old, row_ext_new, col_ext_new;
  slex_pkg::result_t tok_a, tok_b;
  logic va, vb;

  assign b        = item.char_byte;
  assign is_digit = (b >= 8'h30) && (b <= 8'h39);
  assign is_alpha = ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
  assign is_ws    = (b == 8'h20) || (b == 8'h09) || (b == 8'h0A) || (b == 8'h0D);
  assign dval     = 4'(b - 8'h30);
  assign acc10    = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {31'd0, dval};

  // Position after the current byte, saturating.
  always_comb begin
    col_sum = {1'b0, col} + ((b == 8'h09) ? (P+1)'(tab_width) : (P+1)'(1));
    row_adv = row;
    col_adv = col;
    if (b == 8'h0A) begin
      if (row != {P{1'b1}}) row_adv = row + P'(1);
      col_adv = '0;
    end else begin
      col_adv = col_sum[P] ? {P{1'b1}} : col_sum[P-1:0];
    end
  end

  assign row_ext_old = {16'd0, row};
  assign col_ext_old = {16'd0, col};
  assign row_ext_new = {16'd0, row_adv};
  assign col_ext_new = {16'd0, col_adv};

  // Keyword match against the held name, all keywords in parallel.
  always_comb begin
    logic m;
    kw_hit = 1'b0;
    kw_hit_idx = '0;
    for (int k = slex_pkg::KW_COUNT - 1; k >= 0; k--) begin
      m = (plen == slex_pkg::KW_LEN[k]);
      for (int i = 0; i < KEYWORD_MAX_LEN; i++) begin
        if ((i < int'(plen)) && (kbuf[i] != slex_pkg::kw_byte(k, i))) m = 1'b0;
      end
      if (m) begin
        kw_hit = 1'b1;
        kw_hit_idx = 5'(k);
      end
    end
  end

  // Token that closing the pending state gives.
  always_comb begin
    close_code = slex_pkg::C_FAIL;
    close_val  = '0;
    close_frac = '0;
    close_len  = '0;
    case (mode)
      slex_pkg::M_IDENT: begin
        if (kw_hit) close_code = slex_pkg::C_KEYWORD0 + 6'(kw_hit_idx);
        else begin
          close_code = slex_pkg::C_IDENT;
          close_len  = plen;
        end
      end
      slex_pkg::M_NUMERIC: begin
        if (!ovf) begin
          close_code = slex_pkg::C_INT;
          close_val  = acc;
        end
      end
      slex_pkg::M_FLOAT: begin
        if (!ovf) begin
          close_code = slex_pkg::C_REAL;
          close_val  = acc;
          close_frac = frac;
        end
      end
      slex_pkg::M_EQ: close_code = slex_pkg::C_ASSIGN;
      slex_pkg::M_LT: close_code = slex_pkg::C_LESS;
      slex_pkg::M_GT: close_code = slex_pkg::C_GREATER;
      default: close_code = slex_pkg::C_FAIL;
    endcase
  end

  // Next state and the tokens of this byte.
  always_comb begin
    logic cont;
    mode_next = mode;
    plen_next = plen;
    acc_next  = acc;
    frac_next = frac;
    ovf_next  = ovf;
    row_next  = row;
    col_next  = col;
    kbuf_we   = 1'b0;
    kbuf_wa   = '0;
    va = 1'b0;
    vb = 1'b0;
    cont = 1'b0;
    tok_a = '{token_code: close_code, number_value: close_val,
              fraction_digits: close_frac, name_length: close_len,
              row_number: row_ext_old[15:0], column_number: col_ext_old[15:0],
              last_of_run: 1'b0};
    tok_b = '{token_code: slex_pkg::C_EOF, number_value: '0, fraction_digits: '0,
              name_length: '0, row_number: row_ext_old[15:0],
              column_number: col_ext_old[15:0], last_of_run: 1'b0};

    if (item.end_of_text) begin
      va = (mode != slex_pkg::M_INITIAL);
      vb = 1'b1;
      mode_next = slex_pkg::M_INITIAL;
      plen_next = '0;
      acc_next  = '0;
      frac_next = '0;
      ovf_next  = 1'b0;
    end else begin
      // Bytes that continue or complete the pending token.
      case (mode)
        slex_pkg::M_IDENT: begin
          if (is_alpha || is_digit || (b == 8'h5F)) begin
            cont = 1'b1;
            if (int'(plen) < KEYWORD_MAX_LEN) begin
              kbuf_we = 1'b1;
              kbuf_wa = plen[KIDX-1:0];
            end
            if (plen != 8'd255) plen_next = plen + 8'd1;
          end
        end
        slex_pkg::M_NUMERIC: begin
          if (is_digit) begin
            cont = 1'b1;
            if (acc10 > slex_pkg::VALUE_MAX) ovf_next = 1'b1;
            else acc_next = acc10[30:0];
          end else if (b == 8'h2E) begin
            cont = 1'b1;
            mode_next = slex_pkg::M_FLOAT;
          end
        end
        slex_pkg::M_FLOAT: begin
          if (is_digit) begin
            cont = 1'b1;
            if (acc10 > slex_pkg::VALUE_MAX) ovf_next = 1'b1;
            else acc_next = acc10[30:0];
            if (int'(frac) >= slex_pkg::FRAC_LIMIT) ovf_next = 1'b1;
            else frac_next = frac + 4'd1;
          end else if (b == 8'h66) begin
            cont = 1'b1;
            va = 1'b1;
            tok_a.row_number    = row_ext_new[15:0];
            tok_a.column_number = col_ext_new[15:0];
            mode_next = slex_pkg::M_INITIAL;
            acc_next  = '0;
            frac_next = '0;
            ovf_next  = 1'b0;
          end
        end
        slex_pkg::M_EQ, slex_pkg::M_LT, slex_pkg::M_GT: begin
          if (b == 8'h3D) begin
            cont = 1'b1;
            va = 1'b1;
            tok_a.token_code    = close_code + 6'd1;
            tok_a.row_number    = row_ext_new[15:0];
            tok_a.column_number = col_ext_new[15:0];
            mode_next = slex_pkg::M_INITIAL;
          end
        end
        default: cont = 1'b0;
      endcase

      if (!cont) begin
        // The byte closes any pending token and starts over.
        va = (mode != slex_pkg::M_INITIAL);
        mode_next = slex_pkg::M_INITIAL;
        plen_next = '0;
        acc_next  = '0;
        frac_next = '0;
        ovf_next  = 1'b0;
        tok_b.row_number    = row_ext_new[15:0];
        tok_b.column_number = col_ext_new[15:0];
        if (is_ws) begin
          vb = 1'b0;
        end else if (b == 8'h3D) begin
          mode_next = slex_pkg::M_EQ;
        end else if (b == 8'h3C) begin
          mode_next = slex_pkg::M_LT;
        end else if (b == 8'h3E) begin
          mode_next = slex_pkg::M_GT;
        end else if (is_digit) begin
          mode_next = slex_pkg::M_NUMERIC;
          acc_next  = {27'd0, dval};
        end else if (is_alpha) begin
          mode_next = slex_pkg::M_IDENT;
          kbuf_we   = 1'b1;
          kbuf_wa   = '0;
          plen_next = 8'd1;
        end else begin
          vb = 1'b1;
          tok_b.token_code = slex_pkg::single_code(b);
        end
      end
      row_next = row_adv;
      col_next = col_adv;
    end
  end

  // Pack the tokens in order and mark the last one.
  always_comb begin
    qwr = '0;
    qwr.tok0 = va ? tok_a : tok_b;
    qwr.tok1 = tok_b;
    qwr.valid0 = accept && (va || vb);
    qwr.valid1 = accept && va && vb;
    qwr.tok0.last_of_run = !(va && vb);
    qwr.tok1.last_of_run = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= slex_pkg::M_INITIAL;
      plen <= '0;
      acc  <= '0;
      frac <= '0;
      ovf  <= 1'b0;
      row  <= '0;
      col  <= '0;
    end else if (accept) begin
      mode <= mode_next;
      plen <= plen_next;
      acc  <= acc_next;
      frac <= frac_next;
      ovf  <= ovf_next;
      row  <= row_next;
      col  <= col_next;
    end
  end

  // Name characters; an entry is only read below the held length.
  always_ff @(posedge clk) begin
    if (accept && kbuf_we) begin
      kbuf[kbuf_wa] <= b;
    end
  end

endmodule

`default_nettype wire

@@ src/slex_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none

module slex_queue (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire slex_pkg::qwrite_t  qwr,
  input  wire logic               pop,
  output logic                    full,
  output logic                    empty,
  output slex_pkg::result_t       head
);

  localparam int D  = slex_pkg::QUEUE_DEPTH;
  localparam int AW = $clog2(D);

  slex_pkg::result_t mem [D];
  logic [AW-1:0] wp, rp;
  logic [AW:0]   count;
  logic          do_pop;
  logic [1:0]    nwr;

  // Room for two tokens is needed before a byte is taken.
  assign full   = (count > (AW+1)'(D - 2));
  assign empty  = (count == '0);
  assign head   = mem[rp];
  assign do_pop = pop && !empty;
  assign nwr    = {1'b0, qwr.valid0} + {1'b0, qwr.valid1};

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      wp    <= wp + AW'(nwr);
      if (do_pop) rp <= rp + AW'(1);
      count <= count + (AW+1)'(nwr) - (AW+1)'(do_pop);
    end
  end

  // Token storage.
  always_ff @(posedge clk) begin
    if (qwr.valid0) mem[wp] <= qwr.tok0;
    if (qwr.valid1) mem[wp + AW'(1)] <= qwr.tok1;
  end

endmodule

`default_nettype wire

@@ src/slex_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module slex_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              full,
  input wire logic              empty,
  input wire logic              pop,
  input wire slex_pkg::result_t result
);

  // The queue is empty right after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("queue not empty after reset");

  // Full needs stored tokens.
  a_full_not_empty: assert property (@(posedge clk) disable iff (rst) full |-> !empty)
    else $error("full while empty");

  // An end-of-stream token always closes its run.
  a_eof_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.token_code == slex_pkg::C_EOF) |-> result.last_of_run)
    else $error("end token not last of run");

  // Only identifiers carry a length.
  a_len_ident: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop && result.token_code != slex_pkg::C_IDENT) |-> result.name_length == 8'd0)
    else $error("length on non-identifier");

  // Fraction count stays within its limit.
  a_frac_limit: assert property (@(posedge clk) disable iff (rst)
    !empty |-> result.fraction_digits <= 4'd10)
    else $error("fraction count out of range");

endmodule

bind shader_source_lexer_core slex_checker u_slex_checker (
  .clk(clk),
  .rst(rst),
  .full(full),
  .empty(empty),
  .pop(pop),
  .result(result)
);

`default_nettype wire
